// File: sv/hrrn_scheduler_macros.svh
// Assertion macros shared by the scheduler's checker.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef HRRN_SCHEDULER_MACROS_SVH
`define HRRN_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HRRN_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HRRN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/hrrn_pkg.sv
// Shared constants for the highest-response-ratio-next scheduler.
// Depends on nothing; used by the top level and its checker.
package hrrn_pkg;

	localparam int SLOTS_DEF     = 16;
	localparam int ID_BITS_DEF   = 8;
	localparam int TIME_BITS_DEF = 16;

	localparam logic CMD_TICK   = 1'b0;
	localparam logic CMD_ARRIVE = 1'b1;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_DROP = 1'b1;

endpackage

// File: sv/hrrn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module hrrn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: sv/hrrn_scheduler.sv
// Highest-response-ratio-next scheduler: top level with sequencer and shared multiplier.
// Depends on hrrn_pkg and hrrn_ram.
//
// Use: raise start with command, arrival_id and arrival_length; the beat is taken
// at a clock edge where busy is low. busy then stays high until the result is
// ready, and done pulses for one cycle with running_valid, running_id,
// running_left, waiting_count and status. The receiver cannot stall, so the
// result must be taken in that cycle; a new start may be taken in the same one.
// An arrival goes from acceptance straight to the finishing state.
// A tick that must dispatch a job from the waiting jobs first searches them; each
// candidate after the first needs two products from the one shared multiplier.
// The tick then runs the pass that compacts the table and ages the waits of the
// jobs still waiting, which moves one entry per cycle through the table RAM's
// single read and write port.
// Reset empties the table and clears the running job; no clearing pass is needed.
module hrrn_scheduler #(
	parameter int SLOTS     = hrrn_pkg::SLOTS_DEF,
	parameter int ID_BITS   = hrrn_pkg::ID_BITS_DEF,
	parameter int TIME_BITS = hrrn_pkg::TIME_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       command,
	input  logic [ID_BITS-1:0]         arrival_id,
	input  logic [TIME_BITS-1:0]       arrival_length,
	output logic                       busy,
	output logic                       done,
	output logic                       running_valid,
	output logic [ID_BITS-1:0]         running_id,
	output logic [TIME_BITS-1:0]       running_left,
	output logic [$clog2(SLOTS+1)-1:0] waiting_count,
	output logic                       status
);
	import hrrn_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int T  = TIME_BITS;
	localparam int W  = ID_BITS + 2 * T;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_LOAD   = 3'd1;
	localparam logic [2:0] S_M1     = 3'd2;
	localparam logic [2:0] S_M2     = 3'd3;
	localparam logic [2:0] S_SEL    = 3'd4;
	localparam logic [2:0] S_PSTART = 3'd5;
	localparam logic [2:0] S_PRUN   = 3'd6;
	localparam logic [2:0] S_FIN    = 3'd7;

	logic [2:0]         state_q;
	logic [CW-1:0]      cnt_q;
	logic               run_valid_q;
	logic [ID_BITS-1:0] run_job_q;
	logic [T-1:0]       run_left_q;
	logic               done_q;
	logic               status_q;
	logic               tick_q;
	logic               rm_q;
	logic [IW-1:0]      i_q;
	logic [IW-1:0]      j_q;
	logic [IW-1:0]      best_idx_q;
	logic [ID_BITS-1:0] best_job_q;
	logic [T-1:0]       best_len_q;
	logic [T:0]         best_sum_q;
	logic [ID_BITS-1:0] cand_job_q;
	logic [T-1:0]       cand_len_q;
	logic [T:0]         cand_sum_q;
	logic [2*T:0]       prod_q;

	logic               accept;
	logic               need_dispatch;
	logic               ram_we;
	logic [IW-1:0]      ram_waddr;
	logic [W-1:0]       ram_wdata;
	logic               ram_re;
	logic [IW-1:0]      ram_raddr;
	logic [W-1:0]       ram_rdata;
	logic [ID_BITS-1:0] r_job;
	logic [T-1:0]       r_len;
	logic [T-1:0]       r_wait;
	logic [T:0]         r_sum;
	logic [T-1:0]       r_wait_inc;
	logic [T-1:0]       arr_len;
	logic [T:0]         mul_a;
	logic [T-1:0]       mul_b;
	logic [2*T:0]       mul_p;
	logic [CW-1:0]      j_nxt;
	logic [CW-1:0]      src;

	assign accept        = start && (state_q == S_IDLE);
	assign need_dispatch = !run_valid_q || (run_left_q == '0);

	assign r_job      = ram_rdata[W-1 -: ID_BITS];
	assign r_len      = ram_rdata[2*T-1:T];
	assign r_wait     = ram_rdata[T-1:0];
	assign r_sum      = {1'b0, r_len} + {1'b0, r_wait};
	assign r_wait_inc = (r_wait == '1) ? r_wait : r_wait + T'(1);
	assign arr_len    = (arrival_length == '0) ? T'(1) : arrival_length;

	// The one multiplier serves both halves of the cross-multiplied ratio compare.
	assign mul_a = (state_q == S_M2) ? best_sum_q : r_sum;
	assign mul_b = (state_q == S_M2) ? cand_len_q : best_len_q;
	assign mul_p = {{T{1'b0}}, mul_a} * {{(T+1){1'b0}}, mul_b};

	// During the compaction pass, entries above the dispatched one move down by one.
	assign j_nxt = (state_q == S_PRUN) ? CW'(j_q) + CW'(1) : '0;
	assign src   = (rm_q && (j_nxt >= CW'(best_idx_q))) ? j_nxt + CW'(1) : j_nxt;

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				ram_re = accept;
			end
			S_LOAD: begin
				ram_re    = 1'b1;
				ram_raddr = IW'(1);
			end
			S_M1: begin
				ram_re    = 1'b1;
				ram_raddr = i_q + IW'(1);
			end
			S_PSTART, S_PRUN: begin
				ram_re    = 1'b1;
				ram_raddr = src[IW-1:0];
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = j_q;
		ram_wdata = {r_job, r_len, r_wait_inc};
		if (accept && (command == CMD_ARRIVE) && (cnt_q < CW'(SLOTS))) begin
			ram_we    = 1'b1;
			ram_waddr = cnt_q[IW-1:0];
			ram_wdata = {arrival_id, arr_len, {T{1'b0}}};
		end else if (state_q == S_PRUN) begin
			ram_we = 1'b1;
		end
	end

	hrrn_ram #(
		.WIDTH(W),
		.DEPTH(SLOTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			run_valid_q <= 1'b0;
			run_job_q   <= '0;
			run_left_q  <= '0;
			done_q      <= 1'b0;
			status_q    <= ST_OK;
			tick_q      <= 1'b0;
			rm_q        <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q <= ST_OK;
						tick_q   <= (command == CMD_TICK);
						rm_q     <= 1'b0;
						if (command == CMD_ARRIVE) begin
							if (cnt_q < CW'(SLOTS)) begin
								cnt_q <= cnt_q + CW'(1);
							end else begin
								status_q <= ST_DROP;
							end
							state_q <= S_FIN;
						end else if (need_dispatch && (cnt_q != '0)) begin
							state_q <= S_LOAD;
						end else begin
							if (need_dispatch) begin
								run_valid_q <= 1'b0;
								run_job_q   <= '0;
								run_left_q  <= '0;
							end
							state_q <= S_PSTART;
						end
					end
				end
				S_LOAD: begin
					best_idx_q <= '0;
					best_job_q <= r_job;
					best_len_q <= r_len;
					best_sum_q <= r_sum;
					i_q        <= IW'(1);
					state_q    <= (cnt_q > CW'(1)) ? S_M1 : S_SEL;
				end
				S_M1: begin
					cand_job_q <= r_job;
					cand_len_q <= r_len;
					cand_sum_q <= r_sum;
					prod_q     <= mul_p;
					state_q    <= S_M2;
				end
				S_M2: begin
					// Greater or equal lets the later arrival win a tie.
					if (prod_q >= mul_p) begin
						best_idx_q <= i_q;
						best_job_q <= cand_job_q;
						best_len_q <= cand_len_q;
						best_sum_q <= cand_sum_q;
					end
					if (CW'(i_q) + CW'(1) < cnt_q) begin
						i_q     <= i_q + IW'(1);
						state_q <= S_M1;
					end else begin
						state_q <= S_SEL;
					end
				end
				S_SEL: begin
					run_valid_q <= 1'b1;
					run_job_q   <= best_job_q;
					run_left_q  <= best_len_q;
					cnt_q       <= cnt_q - CW'(1);
					rm_q        <= 1'b1;
					state_q     <= S_PSTART;
				end
				S_PSTART: begin
					j_q     <= '0;
					state_q <= (cnt_q == '0) ? S_FIN : S_PRUN;
				end
				S_PRUN: begin
					if (CW'(j_q) + CW'(1) < cnt_q) begin
						j_q <= j_q + IW'(1);
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (tick_q && run_valid_q && (run_left_q != '0)) begin
						run_left_q <= run_left_q - T'(1);
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign running_valid = run_valid_q;
	assign running_id    = run_valid_q ? run_job_q : '0;
	assign running_left  = run_valid_q ? run_left_q : '0;
	assign waiting_count = cnt_q;
	assign status        = status_q;

endmodule

// File: sv/hrrn_checker.sv
// Port-level checker for the scheduler, attached to the top level by bind.
// Depends on hrrn_pkg and hrrn_scheduler_macros.svh.
`include "hrrn_scheduler_macros.svh"

module hrrn_checker #(
	parameter int SLOTS     = hrrn_pkg::SLOTS_DEF,
	parameter int ID_BITS   = hrrn_pkg::ID_BITS_DEF,
	parameter int TIME_BITS = hrrn_pkg::TIME_BITS_DEF
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       done,
	input logic                       running_valid,
	input logic [ID_BITS-1:0]         running_id,
	input logic [TIME_BITS-1:0]       running_left,
	input logic [$clog2(SLOTS+1)-1:0] waiting_count,
	input logic                       status
);
	import hrrn_pkg::*;

	// A result beat only appears once the block has returned to idle.
	`HRRN_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy, "done while busy")

	// Every accepted beat keeps the block busy for at least the next cycle.
	`HRRN_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy && !done,
		"accepted beat did not make the block busy")

	// An idle processor reports neither a job nor remaining time.
	`HRRN_ASSERT_NOW(a_idle_clear, clk, arst_n, done && !running_valid,
		(running_id == '0) && (running_left == '0), "idle processor shows a job")

	// A dropped arrival can only come from a full table.
	`HRRN_ASSERT_NOW(a_drop_full, clk, arst_n, done && (status == ST_DROP),
		waiting_count == ($clog2(SLOTS+1))'(SLOTS), "arrival dropped with room left")

endmodule

bind hrrn_scheduler hrrn_checker #(
	.SLOTS    (SLOTS),
	.ID_BITS  (ID_BITS),
	.TIME_BITS(TIME_BITS)
) u_hrrn_checker (.*);
